// ----- sv/jhds_pkg.sv -----
// Types and constants shared by the JPEG header dimension scanner.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package jhds_pkg;

  // Marker and stuffing bytes.
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_SF0 = 8'hC0;
  localparam logic [7:0] BYTE_SF1 = 8'hC1;
  localparam logic [7:0] BYTE_SF2 = 8'hC2;
  localparam logic [7:0] BYTE_SOS = 8'hDA;
  localparam logic [7:0] BYTE_EOI = 8'hD9;

  // Byte positions inside a frame header, counted from its length field.
  localparam logic [2:0] FLD_HEIGHT_HI = 3'd3;
  localparam logic [2:0] FLD_HEIGHT_LO = 3'd4;
  localparam logic [2:0] FLD_WIDTH_HI  = 3'd5;
  localparam logic [2:0] FLD_WIDTH_LO  = 3'd6;
  localparam logic [2:0] FLD_LAST      = 3'd7;

  typedef enum logic [3:0] {
    PH_SOI_A,
    PH_SOI_B,
    PH_SCAN,
    PH_MARK,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_SOF,
    PH_WAIT
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_SOI  = 3'd1,
    ST_HDR_END = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_ENDED   = 3'd4,
    ST_ZERO    = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/jhds_in_stage.sv -----
// Input register of the JPEG header dimension scanner.
// Depends on jhds_pkg for the input item type.
`default_nettype none

module jhds_in_stage
  import jhds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     advance_i,
  output logic          held_valid_o,
  output in_item_t      held_item_o
);

  logic     valid_q;
  in_item_t item_q;

  // The register frees up in the same cycle that its item moves on.
  assign in_ready_o   = !valid_q || advance_i;
  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jhds_core.sv -----
// Parsing state and per-byte update of the JPEG header dimension scanner.
// Depends on jhds_pkg for the phase and status codes and the item types.
`default_nettype none

module jhds_core
  import jhds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  output out_item_t     res_item_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [2:0]  field_q, field_d;
  logic [15:0] height_q, height_d;
  logic [15:0] width_q, width_d;
  logic [7:0]  len_hi_q, len_hi_d;

  logic [7:0]  b;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;

  assign b        = item_i.data_byte;
  assign seg_len  = {len_hi_q, b};
  assign skip_dec = skip_q - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    field_d     = field_q;
    height_d    = height_q;
    width_d     = width_q;
    len_hi_d    = len_hi_q;
    res_valid_o = 1'b0;
    res_item_o  = '{found: 1'b0, width: 16'd0, height: 16'd0, status: ST_OK};

    unique case (phase_q)
      PH_SOI_A: begin
        if (b != BYTE_FF) begin
          res_valid_o       = 1'b1;
          res_item_o.status = ST_NO_SOI;
          phase_d           = PH_WAIT;
        end else begin
          phase_d = PH_SOI_B;
        end
      end
      PH_SOI_B: begin
        if (b != BYTE_SOI) begin
          res_valid_o       = 1'b1;
          res_item_o.status = ST_NO_SOI;
          phase_d           = PH_WAIT;
        end else begin
          phase_d = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (b == BYTE_FF) begin
          phase_d = PH_MARK;
        end
      end
      PH_MARK: begin
        priority if (b == BYTE_FF || b == BYTE_00) begin
          phase_d = PH_SCAN;
        end else if (b == BYTE_SF0 || b == BYTE_SF1 || b == BYTE_SF2) begin
          field_d  = 3'd0;
          height_d = 16'd0;
          width_d  = 16'd0;
          phase_d  = PH_SOF;
        end else if (b == BYTE_SOS || b == BYTE_EOI) begin
          res_valid_o       = 1'b1;
          res_item_o.status = ST_HDR_END;
          phase_d           = PH_WAIT;
        end else begin
          phase_d = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_d = b;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < 16'd2) begin
          res_valid_o       = 1'b1;
          res_item_o.status = ST_BAD_LEN;
          phase_d           = PH_WAIT;
        end else begin
          skip_d  = seg_len - 16'd2;
          phase_d = (seg_len == 16'd2) ? PH_SCAN : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = PH_SCAN;
        end
      end
      PH_SOF: begin
        if (field_q == FLD_HEIGHT_HI) height_d = {b, 8'd0};
        if (field_q == FLD_HEIGHT_LO) height_d = {height_q[15:8], b};
        if (field_q == FLD_WIDTH_HI)  width_d  = {b, 8'd0};
        if (field_q == FLD_WIDTH_LO)  width_d  = {width_q[15:8], b};
        if (field_q == FLD_LAST) begin
          // The byte after the width settles the result.
          res_valid_o = 1'b1;
          phase_d     = PH_WAIT;
          if (width_q != 16'd0 && height_q != 16'd0) begin
            res_item_o = '{found: 1'b1, width: width_q, height: height_q, status: ST_OK};
          end else begin
            res_item_o.status = ST_ZERO;
          end
        end else begin
          field_d = field_q + 3'd1;
        end
      end
      PH_WAIT: begin
      end
      default: begin
      end
    endcase

    // The last byte of an image always closes it and restarts the parser.
    if (item_i.last_byte) begin
      if (!res_valid_o && phase_q != PH_WAIT) begin
        res_valid_o       = 1'b1;
        res_item_o.status = ST_ENDED;
      end
      phase_d  = PH_SOI_A;
      skip_d   = 16'd0;
      field_d  = 3'd0;
      height_d = 16'd0;
      width_d  = 16'd0;
      len_hi_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SOI_A;
      skip_q   <= 16'd0;
      field_q  <= 3'd0;
      height_q <= 16'd0;
      width_q  <= 16'd0;
      len_hi_q <= 8'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      field_q  <= field_d;
      height_q <= height_d;
      width_q  <= width_d;
      len_hi_q <= len_hi_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jhds_out_stage.sv -----
// Result register of the JPEG header dimension scanner.
// Depends on jhds_pkg for the result item type.
`default_nettype none

module jhds_out_stage
  import jhds_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_item_t load_item_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      valid_q;
  out_item_t item_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= load_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jpeg_header_dimension_scanner_unit.sv -----
// JPEG header dimension scanner: finds the frame dimensions in a byte stream.
// Built from jhds_in_stage, jhds_core and jhds_out_stage; types from jhds_pkg.
//
// Usage: one byte of a JPEG image enters per item on the input channel, with
// last_byte set on the final byte of the image. Exactly one result item leaves
// per image: found, width and height from the first baseline, extended or
// progressive frame header, or a status code saying why none was found.
// Bytes after the result are dropped until the last byte of the image.
//
// Timing: an accepted byte is parsed straight from the input register, and a
// result it causes is registered in the output register when parsed. One byte per
// cycle is sustained while the output is taken.
//
// Stalls: when a result waits and out_ready_i is low, the parser holds the
// byte in its input register and input ready falls once that register is
// full. Bytes that cause no result still wait behind a pending result.
//
// Reset: rst_ni clears both registers and returns the parser to expecting
// the start-of-image marker.
`default_nettype none

module jpeg_header_dimension_scanner_unit
  import jhds_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      held_valid;
  in_item_t  held_item;
  logic      out_free;
  logic      step;
  logic      res_valid;
  out_item_t res_item;

  assign step = held_valid && out_free;

  jhds_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .advance_i    (step),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  jhds_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  jhds_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .load_item_i (res_item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
